@@ rtl/core/bpsa_pkg.sv @@
// shared types, codes and field widths of the block pool slot allocator
package bpsa_pkg;

  // field widths of the stream and configuration ports
  localparam int MODE_W     = 2;
  localparam int BLOCK_W    = 3;
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int MAXB_W     = 4;
  localparam int SPB_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = 3;
  localparam int M_TDATA_W  = 24;
  localparam int M_TUSER_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_BLOCK = 1'd1;

  localparam logic [MAXB_W-1:0] MAXB_RESET = 4'd8;
  localparam logic [SPB_W-1:0]  SPB_RESET  = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_RESET = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_INVALID   = 2'd2,
    STAT_NULL      = 2'd3
  } status_e;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;   // capture the accepted request
    logic step1;  // block search or handle check, memory read
    logic step2;  // commit pop, push or pool clear
    logic emit;   // move the result into the output register
  } cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/bpsa_ctrl.sv @@
// request sequencer of the block pool slot allocator
module bpsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  bpsa_pkg::stat_t  stat_i,
  output bpsa_pkg::cmd_t   cmd_o
);
  import bpsa_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_STEP1 = 2'd1;
  localparam logic [1:0] S_STEP2 = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = s_valid_i;
        if (s_valid_i) state_d = S_STEP1;
      end
      S_STEP1: begin
        cmd_o.step1 = 1'b1;
        state_d     = S_STEP2;
      end
      S_STEP2: begin
        cmd_o.step2 = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        // wait here while the previous result is still held downstream
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/bpsa_dp.sv @@
// datapath of the block pool slot allocator: block state, stacks, result register
module bpsa_dp #(
  parameter int MaxBlockCount = 8,
  parameter int MaxSlots      = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bpsa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [bpsa_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  logic [bpsa_pkg::S_TUSER_W-1:0]      s_tuser_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [bpsa_pkg::M_TDATA_W-1:0]      m_tdata_o,
  output logic [bpsa_pkg::M_TUSER_W-1:0]      m_tuser_o,
  input  bpsa_pkg::cmd_t                      cmd_i,
  output bpsa_pkg::stat_t                     stat_o
);
  import bpsa_pkg::*;

  localparam int BlkW     = (MaxBlockCount > 1) ? $clog2(MaxBlockCount) : 1;
  localparam int OpenW    = $clog2(MaxBlockCount + 1);
  localparam int SlotW    = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int CntW     = $clog2(MaxSlots + 1);
  localparam int AddrW    = BlkW + SlotW;
  localparam int MemDepth = 1 << AddrW;

  // configuration
  logic [MAXB_W-1:0]  maxb_q;
  logic [SPB_W-1:0]   spb_q;

  // per-block stack top and high-water mark; entries at or above the mark
  // were never written since the block opened and hold their own position
  logic [CntW-1:0]    top_q [MaxBlockCount];
  logic [CntW-1:0]    hw_q  [MaxBlockCount];
  logic [OpenW-1:0]   open_q;
  logic [COUNT_W-1:0] total_q;

  // stack and taken-bit memories, valid below each block's high-water mark
  logic [SlotW-1:0]   stack_mem [MemDepth];
  logic               taken_mem [MemDepth];
  logic [SlotW-1:0]   stack_rd_q;
  logic               taken_rd_q;

  // captured request
  mode_e              mode_q;
  logic               null_q;
  logic [BLOCK_W-1:0] fb_q;
  logic [SLOT_W-1:0]  fs_q;

  // step1 results
  logic [BlkW-1:0]    sel_blk_q;
  logic [CntW-1:0]    sel_pos_q;
  logic               fresh_q;
  logic               exh_q;
  logic               bad_q;
  logic               hw_ok_q;

  // result and output register
  status_e            res_status_q;
  logic [BLOCK_W-1:0] res_blk_q;
  logic [SLOT_W-1:0]  res_slot_q;
  logic               m_tvalid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic [M_TUSER_W-1:0] m_tuser_q;

  logic [CntW-1:0]    n_slots;
  logic               find_ok;
  logic [BlkW-1:0]    find_blk;
  logic               can_open;
  logic [BlkW-1:0]    open_blk;
  logic [BlkW-1:0]    fb_idx;
  logic [SlotW-1:0]   fs_idx;
  logic [CntW-1:0]    fb_top_dec;
  logic [SlotW-1:0]   pop_slot;
  logic               push_ok;
  logic               pop_ok;

  always_comb begin
    if (spb_q == '0) begin
      n_slots = CntW'(1);
    end else if (32'(spb_q) > MaxSlots) begin
      n_slots = CntW'(MaxSlots);
    end else begin
      n_slots = CntW'(spb_q);
    end
  end

  // first open block with a free slot
  always_comb begin
    find_ok  = 1'b0;
    find_blk = '0;
    for (int b = MaxBlockCount - 1; b >= 0; b--) begin
      if ((32'(b) < 32'(open_q)) && (top_q[b] < n_slots)) begin
        find_ok  = 1'b1;
        find_blk = BlkW'(b);
      end
    end
  end

  assign can_open   = (32'(open_q) < 32'(maxb_q)) && (32'(open_q) < MaxBlockCount);
  assign open_blk   = BlkW'(open_q);
  assign fb_idx     = BlkW'(fb_q);
  assign fs_idx     = SlotW'(fs_q);
  assign fb_top_dec = top_q[fb_idx] - CntW'(1);
  assign pop_slot   = fresh_q ? SlotW'(sel_pos_q) : stack_rd_q;
  assign pop_ok     = (mode_q == MODE_ALLOC) && !exh_q;
  assign push_ok    = (mode_q == MODE_FREE) && !null_q && !bad_q && hw_ok_q && taken_rd_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxb_q  <= MAXB_RESET;
      spb_q   <= SPB_RESET;
      open_q  <= '0;
      total_q <= '0;
      for (int b = 0; b < MaxBlockCount; b++) begin
        top_q[b] <= '0;
        hw_q[b]  <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_BLOCKS: maxb_q <= cfg_wdata_i[MAXB_W-1:0];
        CFG_SLOTS_PER_BLOCK: begin
          // a new slot count closes every block
          spb_q   <= cfg_wdata_i[SPB_W-1:0];
          open_q  <= '0;
          total_q <= '0;
          for (int b = 0; b < MaxBlockCount; b++) begin
            top_q[b] <= '0;
            hw_q[b]  <= '0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step1) begin
      if ((mode_q == MODE_ALLOC) && !find_ok && can_open) begin
        open_q          <= open_q + OpenW'(1);
        top_q[open_blk] <= '0;
        hw_q[open_blk]  <= '0;
      end
    end else if (cmd_i.step2) begin
      unique case (mode_q)
        MODE_ALLOC: begin
          if (!exh_q) begin
            top_q[sel_blk_q] <= sel_pos_q + CntW'(1);
            if (fresh_q) hw_q[sel_blk_q] <= sel_pos_q + CntW'(1);
            total_q <= total_q + COUNT_W'(1);
          end
        end
        MODE_FREE: begin
          if (push_ok) begin
            top_q[fb_idx] <= fb_top_dec;
            total_q       <= total_q - COUNT_W'(1);
          end
        end
        MODE_RESET: begin
          open_q  <= '0;
          total_q <= '0;
          for (int b = 0; b < MaxBlockCount; b++) begin
            top_q[b] <= '0;
            hw_q[b]  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.step2 && pop_ok) begin
      taken_mem[{sel_blk_q, pop_slot}] <= 1'b1;
    end else if (cmd_i.step2 && push_ok) begin
      taken_mem[{fb_idx, fs_idx}] <= 1'b0;
    end
    if (cmd_i.step2 && push_ok) begin
      stack_mem[{fb_idx, SlotW'(fb_top_dec)}] <= fs_idx;
    end
    stack_rd_q <= stack_mem[{find_blk, SlotW'(top_q[find_blk])}];
    taken_rd_q <= taken_mem[{fb_idx, fs_idx}];
  end

  // request capture and per-step results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(s_tuser_i[MODE_W-1:0]);
      null_q <= s_tuser_i[MODE_W];
      fb_q   <= s_tdata_i[BLOCK_W-1:0];
      fs_q   <= s_tdata_i[BLOCK_W +: SLOT_W];
    end
    if (cmd_i.step1) begin
      sel_blk_q <= find_ok ? find_blk : open_blk;
      sel_pos_q <= find_ok ? top_q[find_blk] : '0;
      fresh_q   <= find_ok ? (top_q[find_blk] == hw_q[find_blk]) : 1'b1;
      exh_q     <= !find_ok && !can_open;
      bad_q     <= (32'(fb_q) >= 32'(open_q)) || (32'(fb_q) >= MaxBlockCount) ||
                   (32'(fs_q) >= 32'(n_slots)) || (top_q[fb_idx] == '0);
      hw_ok_q   <= 32'(fs_q) < 32'(hw_q[fb_idx]);
    end
    if (cmd_i.step2) begin
      res_status_q <= STAT_OK;
      res_blk_q    <= '0;
      res_slot_q   <= '0;
      unique case (mode_q)
        MODE_ALLOC: begin
          if (exh_q) begin
            res_status_q <= STAT_EXHAUSTED;
          end else begin
            res_blk_q  <= BLOCK_W'(sel_blk_q);
            res_slot_q <= SLOT_W'(pop_slot);
          end
        end
        MODE_FREE: begin
          if (null_q) begin
            res_status_q <= STAT_NULL;
          end else if (!push_ok) begin
            res_status_q <= STAT_INVALID;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      m_tdata_q <= {{(M_TDATA_W - COUNT_W - SLOT_W - BLOCK_W){1'b0}},
                    total_q, res_slot_q, res_blk_q};
      m_tuser_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !m_tvalid_q || m_tready_i;
  assign m_tvalid_o      = m_tvalid_q;
  assign m_tdata_o       = m_tdata_q;
  assign m_tuser_o       = m_tuser_q;

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(open_q) <= MaxBlockCount)
    else $error("open block count beyond the pool size");

  a_pop_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step2 && pop_ok |-> 32'(pop_slot) < 32'(n_slots))
    else $error("popped slot beyond the slot count");

  a_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step2 && push_ok && !cfg_we_i |=> total_q == COUNT_W'($past(total_q) - COUNT_W'(1)))
    else $error("live count did not drop on a free");

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step2 && push_ok |-> top_q[fb_idx] != '0)
    else $error("push onto a full stack");

endmodule

@@ rtl/core/block_pool_slot_allocator.sv @@
// Block pool slot allocator: hands out and takes back fixed-size slots from up to
// max_blocks blocks, each with a LIFO free stack; a new block serves slots 0, 1, ...
// in order. Every request gives one result: an allocate, a free, a pool reset or a
// no-op each offer their result after the request is accepted and has passed the
// block search or handle check with the memory read, the commit and the output load,
// and the next request is taken the cycle after the result is loaded, so no new
// request is taken before the last result is loaded; a result that waits on the
// output holds back the next result until it is taken. Blocks open without any
// clearing sweep: each block keeps a high-water mark, so no clearing pass follows
// reset. The user must write configuration only between requests; the block itself
// does not enforce it. Writing slots_per_block also resets the pool.
module block_pool_slot_allocator #(
  parameter int MaxBlockCount = 8,
  parameter int MaxSlots      = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bpsa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bpsa_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // free_block[2:0], free_slot[8:3], zero fill
  input  logic [bpsa_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // mode[1:0], handle_null[2]
  input  logic [bpsa_pkg::S_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // got_block[2:0], got_slot[8:3], live_count[18:9], zero fill
  output logic [bpsa_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // status[1:0]
  output logic [bpsa_pkg::M_TUSER_W-1:0]     m_axis_tuser_o
);
  import bpsa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bpsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bpsa_dp #(
    .MaxBlockCount (MaxBlockCount),
    .MaxSlots      (MaxSlots)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
